FILE: sv/pnl_pkg.sv
package pnl_pkg;

   localparam int QTY_BITS     = 24;
   localparam int PRICE_BITS   = 32;
   localparam int WORD_BITS    = 64;
   localparam int AVG_BITS     = 63;
   localparam int MUL_BITS     = (QTY_BITS > PRICE_BITS) ? QTY_BITS : PRICE_BITS;
   localparam int MUL_CNT_BITS = $clog2(MUL_BITS + 1);
   localparam int DIV_CNT_BITS = $clog2(WORD_BITS + 1);

   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

   typedef enum logic [1:0] {
      ST_APPLIED  = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_REJECTED = 2'd2
   } status_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } mul_stat_type;

   function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] a);
      return a[WORD_BITS-1] ? (~a + 1'b1) : a;
   endfunction

   function automatic logic add_ovf(input logic [WORD_BITS-1:0] a,
                                    input logic [WORD_BITS-1:0] b);
      logic [WORD_BITS-1:0] s;
      s = a + b;
      return (a[WORD_BITS-1] == b[WORD_BITS-1]) && (s[WORD_BITS-1] != a[WORD_BITS-1]);
   endfunction

   function automatic logic sub_ovf(input logic [WORD_BITS-1:0] a,
                                    input logic [WORD_BITS-1:0] b);
      logic [WORD_BITS-1:0] d;
      d = a - b;
      return (a[WORD_BITS-1] != b[WORD_BITS-1]) && (d[WORD_BITS-1] != a[WORD_BITS-1]);
   endfunction

endpackage

FILE: sv/position_pnl_ledger.sv
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  func, buy_side, fill_quantity, fill_price,
//                                             mid_price
// rsp_      out        rsp_valid / rsp_ready  status, net_position, avg_entry_price,
//                                             cash_flow, realized_pnl, unrealized_pnl, total_pnl
//
// One transaction at a time. A shared shift-add multiplier forms each product and a
// restoring divider each quotient; a mark takes one product, a fill up to five
// products and two quotients. A rejected transaction goes straight to the response
// without either unit. Synchronous reset clears the ledger and the fault. A stalled
// response holds in the output register; the next request is still taken and computed,
// and its result waits until that register frees.
module position_pnl_ledger import pnl_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic                        req_buy_side,
   input  logic [QTY_BITS-1:0]         req_fill_quantity,
   input  logic [PRICE_BITS-1:0]       req_fill_price,
   input  logic [PRICE_BITS-1:0]       req_mid_price,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic signed [WORD_BITS-1:0] rsp_net_position,
   output logic [AVG_BITS-1:0]         rsp_avg_entry_price,
   output logic signed [WORD_BITS-1:0] rsp_cash_flow,
   output logic signed [WORD_BITS-1:0] rsp_realized_pnl,
   output logic signed [WORD_BITS-1:0] rsp_unrealized_pnl,
   output logic signed [WORD_BITS-1:0] rsp_total_pnl
);

   typedef enum logic [3:0] {
      S_IDLE, S_FILL, S_NOTIONAL, S_ALLOC_DIV, S_ALLOC_MUL, S_CLOSE_MUL, S_REALIZE,
      S_REVERSE_MUL, S_AVG, S_AVG_DIV, S_MARK_MUL, S_MARK_POST, S_RESULT
   } state_type;

   state_type state_ff;

   // committed ledger
   logic [WORD_BITS-1:0] pos_ff, cost_ff, cash_ff, real_ff, avg_ff, unr_ff, tot_ff;
   logic                 fault_ff;
   // working copy
   logic [WORD_BITS-1:0] w_pos_ff, w_cost_ff, w_cash_ff, w_real_ff, w_avg_ff;
   logic [WORD_BITS-1:0] w_unr_ff, w_tot_ff;
   logic [WORD_BITS-1:0] alloc_ff, rd_ff, pv_ff, oabs_ff;
   logic [QTY_BITS-1:0]  qty_ff, close_ff, rev_ff;
   logic [PRICE_BITS-1:0] price_ff, mark_ff;
   logic                 buy_ff, old_neg_ff, adding_ff;
   status_type           status_ff;

   logic                 mul_start_ff;
   logic [WORD_BITS-1:0] mul_a_ff;
   logic [MUL_BITS-1:0]  mul_b_ff;
   logic                 div_start_ff;
   logic [WORD_BITS-1:0] div_num_ff, div_den_ff;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [WORD_BITS-1:0] rsp_pos_ff, rsp_cash_ff, rsp_real_ff, rsp_unr_ff, rsp_tot_ff;
   logic [AVG_BITS-1:0]  rsp_avg_ff;

   mul_stat_type         mul_stat;
   logic [WORD_BITS-1:0] mul_p;
   logic                 div_done;
   logic [WORD_BITS-1:0] div_q;

   pnl_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mul_a   (mul_a_ff),
      .mul_b   (mul_b_ff),
      .stat    (mul_stat),
      .product (mul_p)
   );

   pnl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   logic [WORD_BITS-1:0] sq, newpos, qty_w, oabs, p_neg, cash_add, cost_add;
   logic [WORD_BITS-1:0] signed_cn, rd, real_sum, cost_sub, unr, tot, div_signed;
   logic                 out_free;

   always_comb begin
      qty_w      = WORD_BITS'(qty_ff);
      sq         = buy_ff ? qty_w : (~qty_w + 1'b1);
      newpos     = pos_ff + sq;
      oabs       = mag(pos_ff);
      p_neg      = ~mul_p + 1'b1;
      cash_add   = buy_ff ? p_neg : mul_p;
      cost_add   = buy_ff ? mul_p : p_neg;
      signed_cn  = old_neg_ff ? p_neg : mul_p;
      rd         = signed_cn - alloc_ff;
      real_sum   = w_real_ff + rd_ff;
      cost_sub   = w_cost_ff - alloc_ff;
      unr        = pv_ff - w_cost_ff;
      tot        = w_cash_ff + pv_ff;
      div_signed = w_cost_ff[WORD_BITS-1] ? (~div_q + 1'b1) : div_q;
      out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         cost_ff      <= '0;
         cash_ff      <= '0;
         real_ff      <= '0;
         avg_ff       <= '0;
         unr_ff       <= '0;
         tot_ff       <= '0;
         fault_ff     <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  buy_ff     <= req_buy_side;
                  qty_ff     <= req_fill_quantity;
                  price_ff   <= req_fill_price;
                  mark_ff    <= req_mid_price;
                  w_pos_ff   <= pos_ff;
                  w_cost_ff  <= cost_ff;
                  w_cash_ff  <= cash_ff;
                  w_real_ff  <= real_ff;
                  w_avg_ff   <= avg_ff;
                  old_neg_ff <= pos_ff[WORD_BITS-1];
                  if (fault_ff) begin
                     status_ff <= ST_REJECTED;
                     state_ff  <= S_RESULT;
                  end else if (req_func) begin
                     state_ff <= S_FILL;
                  end else begin
                     mul_a_ff     <= pos_ff;
                     mul_b_ff     <= MUL_BITS'(req_mid_price);
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_MARK_MUL;
                  end
               end
            end
            S_FILL: begin
               w_pos_ff     <= newpos;
               oabs_ff      <= oabs;
               adding_ff    <= (pos_ff == '0) || (pos_ff[WORD_BITS-1] != buy_ff);
               close_ff     <= (oabs < qty_w) ? QTY_BITS'(oabs) : qty_ff;
               rev_ff       <= (oabs < qty_w) ? (qty_ff - QTY_BITS'(oabs)) : '0;
               mul_a_ff     <= WORD_BITS'(price_ff);
               mul_b_ff     <= MUL_BITS'(qty_ff);
               mul_start_ff <= 1'b1;
               if (add_ovf(pos_ff, sq)) begin
                  status_ff <= ST_OVERFLOW;
                  state_ff  <= S_RESULT;
               end else begin
                  state_ff <= S_NOTIONAL;
               end
            end
            S_NOTIONAL: begin
               if (mul_stat.done) begin
                  w_cash_ff <= w_cash_ff + cash_add;
                  if (mul_stat.ovf || add_ovf(w_cash_ff, cash_add) ||
                      (adding_ff && add_ovf(w_cost_ff, cost_add))) begin
                     status_ff <= ST_OVERFLOW;
                     state_ff  <= S_RESULT;
                  end else if (adding_ff) begin
                     w_cost_ff <= w_cost_ff + cost_add;
                     state_ff  <= S_AVG;
                  end else if (WORD_BITS'(close_ff) != oabs_ff) begin
                     div_num_ff   <= mag(w_cost_ff);
                     div_den_ff   <= oabs_ff;
                     div_start_ff <= 1'b1;
                     state_ff     <= S_ALLOC_DIV;
                  end else begin
                     // whole position closes: the full cost is released
                     alloc_ff     <= w_cost_ff;
                     mul_a_ff     <= WORD_BITS'(price_ff);
                     mul_b_ff     <= MUL_BITS'(close_ff);
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_CLOSE_MUL;
                  end
               end
            end
            S_ALLOC_DIV: begin
               if (div_done) begin
                  mul_a_ff     <= div_signed;
                  mul_b_ff     <= MUL_BITS'(close_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_ALLOC_MUL;
               end
            end
            S_ALLOC_MUL: begin
               if (mul_stat.done) begin
                  alloc_ff     <= mul_p;
                  mul_a_ff     <= WORD_BITS'(price_ff);
                  mul_b_ff     <= MUL_BITS'(close_ff);
                  mul_start_ff <= 1'b1;
                  if (mul_stat.ovf) begin
                     status_ff <= ST_OVERFLOW;
                     state_ff  <= S_RESULT;
                  end else begin
                     state_ff <= S_CLOSE_MUL;
                  end
               end
            end
            S_CLOSE_MUL: begin
               if (mul_stat.done) begin
                  rd_ff <= rd;
                  if (mul_stat.ovf || sub_ovf(signed_cn, alloc_ff)) begin
                     status_ff <= ST_OVERFLOW;
                     state_ff  <= S_RESULT;
                  end else begin
                     state_ff <= S_REALIZE;
                  end
               end
            end
            S_REALIZE: begin
               w_real_ff    <= real_sum;
               w_cost_ff    <= cost_sub;
               mul_a_ff     <= WORD_BITS'(price_ff);
               mul_b_ff     <= MUL_BITS'(rev_ff);
               mul_start_ff <= rev_ff != '0;
               if (add_ovf(w_real_ff, rd_ff) || sub_ovf(w_cost_ff, alloc_ff)) begin
                  status_ff <= ST_OVERFLOW;
                  state_ff  <= S_RESULT;
               end else if (rev_ff != '0) begin
                  state_ff <= S_REVERSE_MUL;
               end else begin
                  state_ff <= S_AVG;
               end
            end
            S_REVERSE_MUL: begin
               if (mul_stat.done) begin
                  w_cost_ff <= w_cost_ff + cost_add;
                  if (mul_stat.ovf || add_ovf(w_cost_ff, cost_add)) begin
                     status_ff <= ST_OVERFLOW;
                     state_ff  <= S_RESULT;
                  end else begin
                     state_ff <= S_AVG;
                  end
               end
            end
            S_AVG: begin
               div_num_ff <= mag(w_cost_ff);
               div_den_ff <= mag(w_pos_ff);
               if (w_pos_ff == '0) begin
                  w_cost_ff    <= '0;
                  w_avg_ff     <= '0;
                  mul_a_ff     <= w_pos_ff;
                  mul_b_ff     <= MUL_BITS'(mark_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_MARK_MUL;
               end else if (w_cost_ff == WORD_MIN) begin
                  status_ff <= ST_OVERFLOW;
                  state_ff  <= S_RESULT;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= S_AVG_DIV;
               end
            end
            S_AVG_DIV: begin
               if (div_done) begin
                  w_avg_ff     <= div_q;
                  mul_a_ff     <= w_pos_ff;
                  mul_b_ff     <= MUL_BITS'(mark_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_MARK_MUL;
               end
            end
            S_MARK_MUL: begin
               if (mul_stat.done) begin
                  pv_ff <= mul_p;
                  if (mul_stat.ovf) begin
                     status_ff <= ST_OVERFLOW;
                     state_ff  <= S_RESULT;
                  end else begin
                     state_ff <= S_MARK_POST;
                  end
               end
            end
            S_MARK_POST: begin
               w_unr_ff <= unr;
               w_tot_ff <= tot;
               state_ff <= S_RESULT;
               if (sub_ovf(pv_ff, w_cost_ff) || add_ovf(w_cash_ff, pv_ff)) begin
                  status_ff <= ST_OVERFLOW;
               end else begin
                  status_ff <= ST_APPLIED;
               end
            end
            S_RESULT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
                  if (status_ff == ST_APPLIED) begin
                     pos_ff      <= w_pos_ff;
                     cost_ff     <= w_cost_ff;
                     cash_ff     <= w_cash_ff;
                     real_ff     <= w_real_ff;
                     avg_ff      <= w_avg_ff;
                     unr_ff      <= w_unr_ff;
                     tot_ff      <= w_tot_ff;
                     rsp_pos_ff  <= w_pos_ff;
                     rsp_avg_ff  <= w_avg_ff[AVG_BITS-1:0];
                     rsp_cash_ff <= w_cash_ff;
                     rsp_real_ff <= w_real_ff;
                     rsp_unr_ff  <= w_unr_ff;
                     rsp_tot_ff  <= w_tot_ff;
                  end else begin
                     // drop the working copy; report the ledger as it stood
                     if (status_ff == ST_OVERFLOW) begin
                        fault_ff <= 1'b1;
                     end
                     rsp_pos_ff  <= pos_ff;
                     rsp_avg_ff  <= avg_ff[AVG_BITS-1:0];
                     rsp_cash_ff <= cash_ff;
                     rsp_real_ff <= real_ff;
                     rsp_unr_ff  <= unr_ff;
                     rsp_tot_ff  <= tot_ff;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready           = state_ff == S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_net_position    = rsp_pos_ff;
   assign rsp_avg_entry_price = rsp_avg_ff;
   assign rsp_cash_flow       = rsp_cash_ff;
   assign rsp_realized_pnl    = rsp_real_ff;
   assign rsp_unrealized_pnl  = rsp_unr_ff;
   assign rsp_total_pnl       = rsp_tot_ff;

endmodule

FILE: sv/pnl_mul.sv
module pnl_mul import pnl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] mul_a,
   input  logic [MUL_BITS-1:0]  mul_b,
   output mul_stat_type         stat,
   output logic [WORD_BITS-1:0] product
);

   logic [WORD_BITS-1:0]    mag_ff;
   logic [MUL_BITS-1:0]     mult_ff;
   logic [WORD_BITS-1:0]    acc_ff;
   logic                    big_ff;
   logic                    neg_ff;
   logic [MUL_CNT_BITS-1:0] cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;

   logic [WORD_BITS-1:0] addend;
   logic [WORD_BITS:0]   sum;
   logic [WORD_BITS-1:0] lim;

   always_comb begin
      addend = mult_ff[MUL_BITS-1] ? mag_ff : '0;
      sum    = {1'b0, acc_ff[WORD_BITS-2:0], 1'b0} + {1'b0, addend};
      lim    = neg_ff ? WORD_MIN : WORD_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mag_ff  <= mag(mul_a);
            neg_ff  <= mul_a[WORD_BITS-1];
            mult_ff <= mul_b;
            acc_ff  <= '0;
            big_ff  <= 1'b0;
            cnt_ff  <= MUL_CNT_BITS'(MUL_BITS);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // shift-add one multiplier bit per cycle, MSB first; sticky on carry out
            acc_ff  <= sum[WORD_BITS-1:0];
            big_ff  <= big_ff | acc_ff[WORD_BITS-1] | sum[WORD_BITS];
            mult_ff <= mult_ff << 1;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == MUL_CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.done = done_ff;
   assign stat.ovf  = big_ff || (acc_ff > lim);
   assign product   = neg_ff ? (~acc_ff + 1'b1) : acc_ff;

endmodule

FILE: sv/pnl_div.sv
module pnl_div import pnl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] num,
   input  logic [WORD_BITS-1:0] den,
   output logic                 done,
   output logic [WORD_BITS-1:0] quo
);

   logic [WORD_BITS-1:0]    num_ff;
   logic [WORD_BITS-1:0]    den_ff;
   logic [WORD_BITS-1:0]    rem_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;

   logic [WORD_BITS-1:0] trial;
   logic                 ge;

   always_comb begin
      trial = {rem_ff[WORD_BITS-2:0], num_ff[WORD_BITS-1]};
      ge    = trial >= den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            cnt_ff  <= DIV_CNT_BITS'(WORD_BITS);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // restoring step; quotient bits shift in behind the dividend
            rem_ff <= ge ? (trial - den_ff) : trial;
            num_ff <= {num_ff[WORD_BITS-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

FILE: sv/pnl_chk.sv
module pnl_chk import pnl_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic signed [WORD_BITS-1:0] rsp_net_position,
   input logic [AVG_BITS-1:0]         rsp_avg_entry_price
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_net_position))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_APPLIED || rsp_status == ST_OVERFLOW ||
                     rsp_status == ST_REJECTED))
      else $error("unknown status code");

   a_flat_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_net_position == '0 |-> rsp_avg_entry_price == '0)
      else $error("flat position with nonzero average price");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in flight");

endmodule

bind position_pnl_ledger pnl_chk u_pnl_chk (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import pnl_pkg::*;

   localparam int N_RANDOM    = 1140;
   localparam int N_PILE_UP   = 140;
   localparam int STALL_LEN   = 3000;
   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_WAIT  = 400;
   localparam logic signed [127:0] MOST_NEG = -(128'sd1 <<< 63);

   typedef struct {
      status_type     status;
      longint         net_position;
      logic [62:0]    avg_entry_price;
      longint         cash_flow;
      longint         realized_pnl;
      longint         unrealized_pnl;
      longint         total_pnl;
   } ledger_rsp_t;

   // typed rows: realized, unrealized and total are all zero
   typedef struct {
      bit          func;
      bit          buy;
      logic [23:0] qty;
      logic [31:0] fill_px;
      logic [31:0] mark_px;
      bit          typed;
      longint      pos;
      logic [62:0] avg;
      longint      cash;
   } stim_row_t;

   localparam int N_ROWS = 18;
   stim_row_t rows [N_ROWS] = '{
      '{1'b0, 1'b0, 24'd0,        32'd0,          32'd5,          1'b1, 0, 63'd0, 0},
      '{1'b1, 1'b1, 24'hFFFFFF,   32'hFFFFFFFF,   32'hFFFFFFFF,   1'b1, 64'sd16777215,
        63'h0FFFFFFFF, -64'sd72057589726183425},
      '{1'b1, 1'b0, 24'hFFFFFF,   32'hFFFFFFFF,   32'd0,          1'b1, 0, 63'd0, 0},
      '{1'b1, 1'b0, 24'd0,        32'd77,         32'd9,          1'b1, 0, 63'd0, 0},
      '{1'b1, 1'b1, 24'd100,      32'd1000,       32'd1010,       1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b1, 24'd50,       32'd1100,       32'd1050,       1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b1, 24'd0,        32'd1234,       32'd1050,       1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b0, 24'd0,        32'd999,        32'd1040,       1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b0, 24'd30,       32'd1200,       32'd1190,       1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b0, 24'd200,      32'd900,        32'd905,        1'b0, 0, 63'd0, 0},
      '{1'b0, 1'b1, 24'hABCDEF,   32'hDEADBEEF,   32'd870,        1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b1, 24'd80,       32'd800,        32'd810,        1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b1, 24'd0,        32'd5,          32'd810,        1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b0, 24'd7,        32'd3,          32'd4,          1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b1, 24'd10,       32'd5,          32'd6,          1'b0, 0, 63'd0, 0},
      '{1'b0, 1'b0, 24'd0,        32'd0,          32'd0,          1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b0, 24'd3,        32'd7,          32'hFFFFFFFF,   1'b0, 0, 63'd0, 0},
      '{1'b1, 1'b1, 24'd1,        32'd0,          32'd1,          1'b0, 0, 63'd0, 0}
   };

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_func;
   logic                        req_buy_side;
   logic [QTY_BITS-1:0]         req_fill_quantity;
   logic [PRICE_BITS-1:0]       req_fill_price;
   logic [PRICE_BITS-1:0]       req_mid_price;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [1:0]                  rsp_status;
   logic signed [WORD_BITS-1:0] rsp_net_position;
   logic [AVG_BITS-1:0]         rsp_avg_entry_price;
   logic signed [WORD_BITS-1:0] rsp_cash_flow;
   logic signed [WORD_BITS-1:0] rsp_realized_pnl;
   logic signed [WORD_BITS-1:0] rsp_unrealized_pnl;
   logic signed [WORD_BITS-1:0] rsp_total_pnl;

   position_pnl_ledger dut (.*);

   // ledger shadow state
   longint      led_pos, led_cost, led_cash, led_real, led_unr, led_tot;
   logic [62:0] led_avg;
   bit          led_fault;

   ledger_rsp_t pending_rsps [$];
   int          errors = 0;
   int          rsp_count = 0;
   int          idle_cycles = 0;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_buy_side = 1'b0;
      req_fill_quantity = '0;
      req_fill_price = '0;
      req_mid_price = '0;
      rsp_ready = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit fits64(logic signed [127:0] v);
      return v[127:63] == {65{v[63]}};
   endfunction

   function automatic logic signed [127:0] wabs(logic signed [127:0] v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic ledger_rsp_t ledger_snapshot(status_type st);
      ledger_rsp_t r;
      r.status = st;
      r.net_position = led_pos;
      r.avg_entry_price = led_avg;
      r.cash_flow = led_cash;
      r.realized_pnl = led_real;
      r.unrealized_pnl = led_unr;
      r.total_pnl = led_tot;
      return r;
   endfunction

   // apply one transaction to the shadow ledger, return the expected response
   function automatic ledger_rsp_t ledger_predict(bit func, bit buy, logic [23:0] qty,
                                                  logic [31:0] fill_px,
                                                  logic [31:0] mark_px);
      logic signed [127:0] pos, cost, cash, rlz, avg, q, px, mk;
      logic signed [127:0] sq, newpos, notional, oabs, close, rev, alloc, cn, rd, rn;
      logic signed [127:0] pv, unr, tot;
      bit ok;
      pos = led_pos;
      cost = led_cost;
      cash = led_cash;
      rlz = led_real;
      avg = {65'd0, led_avg};
      q = {104'd0, qty};
      px = {96'd0, fill_px};
      mk = {96'd0, mark_px};
      ok = 1'b1;
      if (led_fault) return ledger_snapshot(ST_REJECTED);
      if (func) begin
         sq = buy ? q : -q;
         newpos = pos + sq;
         ok &= fits64(newpos);
         notional = px * q;
         ok &= fits64(notional);
         cash = buy ? cash - notional : cash + notional;
         ok &= fits64(cash);
         if (pos == 0 || (pos > 0 && sq > 0) || (pos < 0 && sq < 0)) begin
            cost = buy ? cost + notional : cost - notional;
            ok &= fits64(cost);
         end else begin
            oabs = wabs(pos);
            close = (oabs < q) ? oabs : q;
            rev = q - close;
            alloc = cost;
            // pro-rata share: truncating quotient times closed quantity
            if (close != oabs) begin
               alloc = (cost / oabs) * close;
               ok &= fits64(alloc);
            end
            cn = px * close;
            ok &= fits64(cn);
            rd = ((pos > 0) ? cn : -cn) - alloc;
            ok &= fits64(rd);
            rlz = rlz + rd;
            ok &= fits64(rlz);
            cost = cost - alloc;
            ok &= fits64(cost);
            if (rev > 0) begin
               rn = px * rev;
               ok &= fits64(rn);
               cost = buy ? cost + rn : cost - rn;
               ok &= fits64(cost);
            end
         end
         pos = newpos;
         if (pos == 0) begin
            cost = 0;
            avg = 0;
         end else if (cost == MOST_NEG) begin
            ok = 1'b0;
         end else begin
            avg = wabs(cost) / wabs(pos);
         end
      end
      pv = mk * pos;
      ok &= fits64(pv);
      unr = pv - cost;
      ok &= fits64(unr);
      tot = cash + pv;
      ok &= fits64(tot);
      if (!ok) begin
         led_fault = 1'b1;
         return ledger_snapshot(ST_OVERFLOW);
      end
      led_pos = pos[63:0];
      led_cost = cost[63:0];
      led_cash = cash[63:0];
      led_real = rlz[63:0];
      led_avg = avg[62:0];
      led_unr = unr[63:0];
      led_tot = tot[63:0];
      return ledger_snapshot(ST_APPLIED);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   task automatic send_order(bit func, bit buy, logic [23:0] qty, logic [31:0] fill_px,
                             logic [31:0] mark_px, bit typed, ledger_rsp_t typed_rsp);
      int n;
      ledger_rsp_t predicted;
      n = gap_len();
      @(negedge clock);
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_func = func;
      req_buy_side = buy;
      req_fill_quantity = qty;
      req_fill_price = fill_px;
      req_mid_price = mark_px;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = ledger_predict(func, buy, qty, fill_px, mark_px);
      pending_rsps.push_back(typed ? typed_rsp : predicted);
   endtask

   // stimulus
   initial begin
      ledger_rsp_t tr;
      bit          f, b, wide;
      logic [23:0] q;
      logic [31:0] fp, mp;
      led_pos = 0; led_cost = 0; led_cash = 0; led_real = 0;
      led_unr = 0; led_tot = 0; led_avg = '0; led_fault = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         tr = '{ST_APPLIED, rows[i].pos, rows[i].avg, rows[i].cash, 0, 0, 0};
         send_order(rows[i].func, rows[i].buy, rows[i].qty, rows[i].fill_px,
                    rows[i].mark_px, rows[i].typed, tr);
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         wide = ($urandom_range(0, 29) == 0);
         f = ($urandom_range(0, 9) != 0);
         q = wide ? 24'($urandom) : (($urandom_range(0, 49) == 0) ? 24'd0
                                                                 : 24'($urandom_range(1, 4000)));
         fp = wide ? $urandom : $urandom_range(1, 70000);
         mp = wide ? $urandom : $urandom_range(0, 70000);
         // steer back toward flat when the position grows large
         if (led_pos > 64'sd67108864) b = 1'b0;
         else if (led_pos < -64'sd67108864) b = 1'b1;
         else b = $urandom_range(0, 1);
         send_order(f, b, q, fp, mp, 1'b0, tr);
      end

      // pile up a long position, then mark it high enough to overflow
      for (int i = 0; i < N_PILE_UP; i++)
         send_order(1'b1, 1'b1, 24'hFFFFFF, 32'd1, 32'd0, 1'b0, tr);
      send_order(1'b0, 1'b0, 24'd0, 32'd0, 32'hFFFFFFFF, 1'b0, tr);
      for (int i = 0; i < 3; i++)
         send_order(1'b1, i[0], 24'($urandom), $urandom, $urandom, 1'b0, tr);

      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_rsps.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // response side readiness, with one long hold-off to back up the request side
   initial begin
      bit stalled;
      stalled = 1'b0;
      forever begin
         @(negedge clock);
         if (!stalled && rsp_count >= 400) begin
            stalled = 1'b1;
            rsp_ready = 1'b0;
            repeat (STALL_LEN) @(negedge clock);
         end else if ($urandom_range(0, 199) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(20, 80)) @(negedge clock);
         end
         rsp_ready = ($urandom_range(0, 3) != 0);
      end
   end

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d (0x%h), actual %0d (0x%h)",
                name, $signed(exp_v), exp_v, $signed(act_v), act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      ledger_rsp_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_rsps.size() == 0) begin
            $error("response transaction with no expectation pending");
            errors++;
         end else begin
            e = pending_rsps.pop_front();
            check_field("status", 64'(e.status), 64'(rsp_status));
            check_field("net_position", e.net_position, rsp_net_position);
            check_field("avg_entry_price", 64'(e.avg_entry_price), 64'(rsp_avg_entry_price));
            check_field("cash_flow", e.cash_flow, rsp_cash_flow);
            check_field("realized_pnl", e.realized_pnl, rsp_realized_pnl);
            check_field("unrealized_pnl", e.unrealized_pnl, rsp_unrealized_pnl);
            check_field("total_pnl", e.total_pnl, rsp_total_pnl);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
